// ----- hw/rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int WORD_W        = 32;
    localparam int KIND_W        = 3;
    localparam int CAP_W         = 11;
    localparam int CAP_RESET     = 1024;
    localparam int OUT_W         = 72;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FIRST,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_LAST,
        OP_POP_FRONT,
        OP_POP_BACK
    } op_t;

    typedef struct packed {
        op_t  op;
        logic cap_front;
        logic cap_rear;
        logic load_out;
        logic ok;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
    } status_t;

endpackage

// ----- hw/rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/cdq_ctrl.sv -----
// Controller: decodes each operation and sequences read, result and handshake.
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KIND_W-1:0] kind,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  status_t           status,
    output cmd_t              cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   ok_reg, ok_next;
    logic   rd_front_reg, rd_front_next;

    op_t    dec_op;
    logic   dec_ok;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        dec_op = OP_NONE;
        dec_ok = 1'b0;
        unique case (kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (!status.full)
                begin
                    dec_ok = 1'b1;
                    if (status.empty)
                        dec_op = OP_PUSH_FIRST;
                    else if (kind == KIND_PUSH_FRONT)
                        dec_op = OP_PUSH_FRONT;
                    else
                        dec_op = OP_PUSH_BACK;
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (!status.empty)
                begin
                    dec_ok = 1'b1;
                    if (status.single)
                        dec_op = OP_POP_LAST;
                    else if (kind == KIND_POP_FRONT)
                        dec_op = OP_POP_FRONT;
                    else
                        dec_op = OP_POP_BACK;
                end
            end
            KIND_PEEK:
            begin
                dec_ok = 1'b1;
            end
            default:
            begin
                dec_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        rd_front_next  = rd_front_reg;
        cmd            = '{op: OP_NONE, cap_front: 1'b0, cap_rear: 1'b0,
                           load_out: 1'b0, ok: ok_reg};

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op        = dec_op;
                    ok_next       = dec_ok;
                    rd_front_next = (dec_op == OP_POP_FRONT);
                    // pops that leave entries need the new end word from the RAM
                    if (dec_op == OP_POP_FRONT || dec_op == OP_POP_BACK)
                        state_next = S_READ;
                    else
                        state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                cmd.cap_front = rd_front_reg;
                cmd.cap_rear  = !rd_front_reg;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            rd_front_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            rd_front_reg  <= rd_front_next;
        end
    end

endmodule

// ----- hw/rtl/cdq_datapath.sv -----
// Datapath: ring pointers, capacity, end-word registers, storage and result register.
`timescale 1ns / 1ps

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [WORD_W-1:0] push_value,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    output logic [OUT_W-1:0]  out_data
);

    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic              empty_reg, empty_next;
    logic [CW-1:0]     cap_reg, cap_next;
    logic [WORD_W-1:0] front_reg, front_next;
    logic [WORD_W-1:0] rear_reg, rear_next;
    logic [OUT_W-1:0]  out_reg;

    logic [CW-1:0]     head_inc, tail_inc;
    logic [AW-1:0]     head_up, head_down, tail_up, tail_down, cap_last;
    logic [31:0]       cfg_wide;
    logic              full;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] front_out, rear_out;

    // ring steps; indices always stay below the capacity
    assign head_inc  = CW'(head_reg) + CW'(1);
    assign tail_inc  = CW'(tail_reg) + CW'(1);
    assign cap_last  = AW'(cap_reg - CW'(1));
    assign head_up   = (head_inc >= cap_reg) ? '0 : AW'(head_inc);
    assign tail_up   = (tail_inc >= cap_reg) ? '0 : AW'(tail_inc);
    assign head_down = (head_reg == '0) ? cap_last : head_reg - AW'(1);
    assign tail_down = (tail_reg == '0) ? cap_last : tail_reg - AW'(1);

    assign full          = !empty_reg && (tail_up == head_reg);
    assign status.empty  = empty_reg;
    assign status.full   = full;
    assign status.single = (head_reg == tail_reg);

    assign cfg_wide = 32'(cfg_wr_data);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        cap_next   = cap_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        wr_en      = 1'b0;
        wr_addr    = head_down;
        rd_en      = 1'b0;
        rd_addr    = head_up;

        case (cmd.op)
            OP_PUSH_FIRST:
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                wr_en      = 1'b1;
                wr_addr    = '0;
                front_next = push_value;
                rear_next  = push_value;
            end
            OP_PUSH_FRONT:
            begin
                head_next  = head_down;
                wr_en      = 1'b1;
                wr_addr    = head_down;
                front_next = push_value;
            end
            OP_PUSH_BACK:
            begin
                tail_next = tail_up;
                wr_en     = 1'b1;
                wr_addr   = tail_up;
                rear_next = push_value;
            end
            OP_POP_LAST:
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
            end
            OP_POP_FRONT:
            begin
                head_next = head_up;
                rd_en     = 1'b1;
                rd_addr   = head_up;
            end
            OP_POP_BACK:
            begin
                tail_next = tail_down;
                rd_en     = 1'b1;
                rd_addr   = tail_down;
            end
            default:
            begin
            end
        endcase

        if (cmd.cap_front)
            front_next = rd_data;
        if (cmd.cap_rear)
            rear_next = rd_data;

        // a capacity write also empties the ring; zero counts as one
        if (cfg_wr_en)
        begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
            if (cfg_wide == 32'd0)
                cap_next = CW'(1);
            else if (cfg_wide > 32'(DEPTH))
                cap_next = CW'(DEPTH);
            else
                cap_next = CW'(cfg_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= CW'(CAP_INIT);
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            cap_reg   <= cap_next;
        end
    end

    assign front_out = empty_reg ? '1 : front_reg;
    assign rear_out  = empty_reg ? '1 : rear_reg;

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
        if (cmd.load_out)
        begin
            out_reg <= {5'b0, full, empty_reg, rear_out, front_out, cmd.ok};
        end
    end

    assign out_data = out_reg;

    cdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- hw/rtl/circular_deque.sv -----
// Top level of the circular deque: controller, datapath and stream ports.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-----------------------------------------
//  s         | in  | s_tvalid / s_tready | tuser: kind; tdata: push_value
//  m         | out | m_tvalid / m_tready | tdata: ok, front, rear, is_empty, is_full
//  cfg       | in  | cfg_wr_en           | cfg_wr_data: capacity
//
// Pushes, peeks, refused and unknown operations and pops that empty the deque go
// from idle to finish; pops that leave entries pass through a read state between,
// for the registered RAM read of the new end word. The pointers and end-word registers
// keep front/rear at hand. A new word is taken only once the controller is back in idle.
// Reset empties the deque and sets capacity to min(1024, DEPTH); no clear pass.
// A stalled output holds the finished word; one more word is taken and executed,
// and its result waits in the controller until the output moves.
`timescale 1ns / 1ps

module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,    // [31:0] push_value
    input  logic [KIND_W-1:0] s_tuser,    // [2:0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,    // [0] ok, [32:1] front_value, [64:33] rear_value,
                                          // [65] is_empty, [66] is_full, [71:67] zero
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .push_value  (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_data    (m_tdata)
    );

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// Port-level checks for the circular deque, bound to the top level.
`timescale 1ns / 1ps

module cdq_checker
    import cdq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [WORD_W-1:0] s_tdata,
    input logic [KIND_W-1:0] s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              cfg_wr_en,
    input logic [CAP_W-1:0]  cfg_wr_data
);

    // stalled result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // an empty deque reports -1 at both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65] |-> m_tdata[32:1] == '1 && m_tdata[64:33] == '1)
        else $error("empty deque reported an end word");

    // empty and full never together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[65] && m_tdata[66]))
        else $error("empty and full flagged together");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
